/* design/bpmd_pkg.sv */
package bpmd_pkg;

  localparam int TILT_W  = 25;
  localparam int ACCEL_W = 24;
  localparam int TGT_W   = 22;
  localparam int GAIN_W  = 16;
  localparam int DRV_W   = 10;
  localparam int ERR_W   = 26;
  localparam int DIFF_W  = 27;
  // wide enough for a zero-extended gain and for the correction reciprocal
  localparam int MUL_A_W = 25;
  localparam int PROD_W  = MUL_A_W + DIFF_W;
  localparam int TERM_W  = PROD_W - 8;
  localparam int ACC_W   = 38;
  localparam int OUT_W   = 26;
  localparam int OFS_W   = 22;
  localparam int OFS_X_W = OFS_W + 1;
  localparam int CFG_IDX_W = 2;

  // drive divider: numerator and denominator widths
  localparam int DIV_NUM_W = 29;
  localparam int DIV_DEN_W = 25;

  localparam logic [GAIN_W-1:0] P_GAIN_RST = 16'd3840;
  localparam logic [GAIN_W-1:0] I_GAIN_RST = 16'd384;
  localparam logic [GAIN_W-1:0] D_GAIN_RST = 16'd7680;

  localparam logic signed [ACC_W-1:0]   LIM_400_A = 38'sd26214400;
  localparam logic signed [OUT_W-1:0]   LIM_400_O = 26'sd26214400;
  localparam logic signed [OUT_W-1:0]   DEADBAND  = 26'sd327680;
  localparam logic signed [OUT_W-1:0]   CORR_THR  = 26'sd655360;
  localparam logic signed [TILT_W-1:0]  LIM_30_T  = 25'sd1966080;
  localparam logic signed [OFS_X_W-1:0] LIM_30_X  = 23'sd1966080;
  localparam logic signed [OFS_X_W-1:0] DRIFT     = 23'sd98;
  localparam logic signed [ACCEL_W-1:0] ARM_WIN   = 24'sd32768;

  localparam logic [DIV_NUM_W-1:0] DRIVE_NUM  = 29'd360448000;
  localparam logic [DIV_DEN_W-1:0] DRIVE_BIAS = 25'd589824;
  localparam logic [DRV_W-1:0]     DRIVE_SUB  = 10'd5;

  // 15/1000 taken as 3/8 then /25; ceil(2^28/25) is exact over the clamped output range
  localparam int                        CORR_SHIFT = 28;
  localparam logic signed [MUL_A_W-1:0] CORR_RECIP = 25'sd10737419;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN = 2'd0,
    REG_I_GAIN = 2'd1,
    REG_D_GAIN = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORR,
    ST_CORR_WAIT,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM,
    ST_DRV_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MSEL_I,
    MSEL_P,
    MSEL_D,
    MSEL_C
  } mul_sel_t;

  // q8.8 product back to q16, rounding toward zero
  function automatic logic signed [TERM_W-1:0] trunc256(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + (p[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
    return $signed(t[PROD_W-1:8]);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat400(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    if (x > LIM_400_A) y = LIM_400_A;
    else if (x < -LIM_400_A) y = -LIM_400_A;
    else y = x;
    return $signed(y[OUT_W-1:0]);
  endfunction

endpackage

/* design/bpmd_div.sv */
module bpmd_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] nq;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit a cycle; quotient shifts in behind numerator
  assign trial = {rem, nq[NUM_W-1]};
  assign ge    = trial >= {1'b0, dreg};
  assign diff  = trial - {1'b0, dreg};
  assign quot  = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq   <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq  <= {nq[NUM_W-2:0], ge};
    end
  end

endmodule

/* design/balance_pid_motor_drive_core.sv */
// Balance PID controller and motor drive. One transaction per control tick: the block takes
// tilt, accelerometer and target angles (signed Q16 degrees) and returns one result with the
// controller output, the shared motor drive value and the running flag. Items are handled one
// at a time; in_ready is high only while idle. A tick whose output is nonzero also runs the
// 29-step restoring divider that forms the drive. When the previous output exceeds 10, the
// feedback correction is added first: a reciprocal product on the shared 25x27 multiplier
// that also forms the three gain products, one per cycle. A result still waiting for
// out_ready holds the next tick in its last cycle. Gains are written through cfg_we at any
// time the block is idle.
module balance_pid_motor_drive_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [bpmd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bpmd_pkg::GAIN_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [bpmd_pkg::TILT_W-1:0]     tilt_angle,
  input  logic signed [bpmd_pkg::ACCEL_W-1:0]    accel_angle,
  input  logic signed [bpmd_pkg::TGT_W-1:0]      target_angle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [bpmd_pkg::DRV_W-1:0]      motor_drive,
  output logic signed [bpmd_pkg::OUT_W-1:0]      controller_output,
  output logic                                   running
);

  import bpmd_pkg::*;

  state_t state, state_next;

  logic [GAIN_W-1:0] p_gain, i_gain, d_gain;

  logic                       armed;
  logic signed [OUT_W-1:0]    integral_sum;
  logic signed [ERR_W-1:0]    previous_error;
  logic signed [OUT_W-1:0]    previous_output;
  logic signed [OFS_W-1:0]    balance_offset;

  logic signed [TILT_W-1:0]   tilt;
  logic signed [TGT_W-1:0]    target;
  logic signed [ERR_W-1:0]    err;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [OUT_W-1:0]    res;
  logic signed [DRV_W-1:0]    drive;

  logic                       in_fire, load_out, div_start, div_done;
  logic [DIV_NUM_W-1:0]       div_num, div_quot;
  logic [DIV_DEN_W-1:0]       div_den;
  mul_sel_t                   mul_sel;

  logic signed [ERR_W-1:0]    err_base, corr_mag;
  logic [OUT_W-1:0]           prev_abs;
  logic [ERR_W:0]             prev_x3;
  logic [ERR_W-3:0]           corr_y;
  logic                       corr_on, arm_win;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [TERM_W-1:0]   term;
  logic signed [ACC_W-1:0]    sum;
  logic signed [OUT_W-1:0]    res_c, res_db, res_fin;
  logic [OUT_W-1:0]           res_abs;
  logic                       fall;
  logic signed [OFS_X_W-1:0]  ofs_step;
  logic signed [OFS_W-1:0]    ofs_new;
  logic signed [DRV_W-1:0]    drv_mag;

  assign in_fire  = in_valid && in_ready;
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  // error before feedback correction
  assign err_base = ERR_W'(tilt_angle) - ERR_W'(balance_offset) - ERR_W'(target_angle);
  assign arm_win  = (accel_angle > -ARM_WIN) && (accel_angle < ARM_WIN);

  assign prev_abs = previous_output[OUT_W-1] ? OUT_W'(-previous_output)
                                             : OUT_W'(previous_output);
  // floor(3|out|/8), then the reciprocal product gives the /25
  assign prev_x3  = {prev_abs, 1'b0} + {1'b0, prev_abs};
  assign corr_y   = prev_x3[ERR_W:3];
  assign corr_on  = (previous_output > CORR_THR) || (previous_output < -CORR_THR);
  assign corr_mag = $signed(ERR_W'(prod[PROD_W-1:CORR_SHIFT]));

  // shared multiplier, registered into prod every cycle
  always_comb begin
    case (mul_sel)
      MSEL_C:  mul_a = CORR_RECIP;
      MSEL_P:  mul_a = $signed(MUL_A_W'(p_gain));
      MSEL_D:  mul_a = $signed(MUL_A_W'(d_gain));
      default: mul_a = $signed(MUL_A_W'(i_gain));
    endcase
    case (mul_sel)
      MSEL_C:  mul_b = $signed(DIFF_W'(corr_y));
      MSEL_D:  mul_b = DIFF_W'(err) - DIFF_W'(previous_error);
      default: mul_b = DIFF_W'(err);
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign term  = trunc256(prod);

  // final sum, clamps, deadband and fall cut
  assign sum     = acc + ACC_W'(term);
  assign res_c   = sat400(sum);
  assign res_db  = ((res_c > -DEADBAND) && (res_c < DEADBAND)) ? '0 : res_c;
  assign fall    = (tilt > LIM_30_T) || (tilt < -LIM_30_T) || !armed;
  assign res_fin = fall ? '0 : res_db;
  assign res_abs = res_fin[OUT_W-1] ? OUT_W'(-res_fin) : OUT_W'(res_fin);

  always_comb begin
    ofs_step = OFS_X_W'(balance_offset);
    if (res_fin > 0) ofs_step = ofs_step - DRIFT;
    else if (res_fin < 0) ofs_step = ofs_step + DRIFT;
    if (ofs_step > LIM_30_X) ofs_step = LIM_30_X;
    else if (ofs_step < -LIM_30_X) ofs_step = -LIM_30_X;
    ofs_new = OFS_W'(ofs_step);
  end

  assign drv_mag = $signed(DRV_W'(div_quot[DRV_W-2:0]) - DRIVE_SUB);

  assign div_num = DRIVE_NUM;
  assign div_den = res_abs[DIV_DEN_W-1:0] + DRIVE_BIAS;

  bpmd_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_CORR;
      ST_CORR:      state_next = corr_on ? ST_CORR_WAIT : ST_MUL_I;
      ST_CORR_WAIT: state_next = ST_MUL_I;
      ST_MUL_I:     state_next = ST_MUL_P;
      ST_MUL_P:     state_next = ST_MUL_D;
      ST_MUL_D:     state_next = ST_SUM;
      ST_SUM:       state_next = (res_fin != 0) ? ST_DRV_WAIT : ST_DONE;
      ST_DRV_WAIT:  if (div_done) state_next = ST_DONE;
      ST_DONE:      if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_sel   = MSEL_I;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_CORR:  mul_sel = MSEL_C;
      ST_MUL_P: mul_sel = MSEL_P;
      ST_MUL_D: mul_sel = MSEL_D;
      ST_SUM:   div_start = (res_fin != 0);
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain <= P_GAIN_RST;
      i_gain <= I_GAIN_RST;
      d_gain <= D_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_P_GAIN: p_gain <= cfg_data;
        REG_I_GAIN: i_gain <= cfg_data;
        REG_D_GAIN: d_gain <= cfg_data;
        default:    ;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      integral_sum    <= '0;
      previous_error  <= '0;
      previous_output <= '0;
      balance_offset  <= '0;
    end else begin
      if (in_fire && arm_win) armed <= 1'b1;
      if (state == ST_MUL_P) integral_sum <= sat400(ACC_W'(integral_sum) + ACC_W'(term));
      if (state == ST_SUM) begin
        previous_error  <= err;
        previous_output <= res_fin;
        if (fall) begin
          armed          <= 1'b0;
          integral_sum   <= '0;
          balance_offset <= '0;
        end else if (target == 0) begin
          balance_offset <= ofs_new;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (in_fire) begin
      tilt   <= tilt_angle;
      target <= target_angle;
      err    <= err_base;
    end
    if (state == ST_CORR_WAIT) begin
      err <= previous_output[OUT_W-1] ? err - corr_mag : err + corr_mag;
    end
    if (state == ST_MUL_D) acc <= ACC_W'(term) + ACC_W'(integral_sum);
    if (state == ST_SUM) begin
      res   <= res_fin;
      drive <= '0;
    end
    if (state == ST_DRV_WAIT && div_done) drive <= res[OUT_W-1] ? -drv_mag : drv_mag;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      motor_drive       <= drive;
      controller_output <= res;
      running           <= armed;
    end
  end

  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running |-> controller_output == 0)
    else $error("output not zero while stopped");

  a_drive_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && controller_output == 0 |-> motor_drive == 0)
    else $error("drive not zero for zero output");

  a_drive_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && controller_output != 0 |->
      motor_drive != 0 && motor_drive[DRV_W-1] == controller_output[OUT_W-1])
    else $error("drive sign does not follow output");

  a_integral_lim: assert property (@(posedge clk) disable iff (rst)
    integral_sum <= LIM_400_O && integral_sum >= -LIM_400_O)
    else $error("integral outside clamp");

  a_offset_lim: assert property (@(posedge clk) disable iff (rst)
    OFS_X_W'(balance_offset) <= LIM_30_X && OFS_X_W'(balance_offset) >= -LIM_30_X)
    else $error("balance offset outside limit");

endmodule
